FILE: rtl/rng_bias_autocorrelation_monitor_assert.svh
// assertion macros for the random bit health monitor checker
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef RNG_BIAS_AUTOCORRELATION_MONITOR_ASSERT_SVH
`define RNG_BIAS_AUTOCORRELATION_MONITOR_ASSERT_SVH

// same-cycle implication, inactive during reset
`define RBAM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rbam check failed");

// next-cycle implication, inactive during reset
`define RBAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rbam check failed");

`endif

FILE: rtl/rbam_pkg.sv
// shared types, constants and helpers of the random bit health monitor
// no dependencies
`timescale 1ns / 1ps

package rbam_pkg;

  localparam int RING_DEPTH  = 128;
  localparam int LAG_COUNT   = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int CNT_W     = 20;
  localparam int IVL_W     = 16;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W    = 2;
  localparam int LAG_W     = 5;
  localparam int SUM_W     = 9;

  localparam int RING_AW  = $clog2(RING_DEPTH);
  localparam int WIN_W    = $clog2(RING_DEPTH + 1);
  localparam int LEN_W    = $clog2(RING_DEPTH + LAG_COUNT + 1);
  localparam int ACC_W    = WIN_W + 1;
  localparam int LAG_IW   = (LAG_COUNT > 1) ? $clog2(LAG_COUNT) : 1;
  localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int RC_BIT_W = $clog2(CNT_W);

  // stream payload layout
  localparam int IN_DATA_W  = 8;
  localparam int OFS_TOTAL  = 0;
  localparam int OFS_ZEROS  = OFS_TOTAL + CNT_W;
  localparam int OFS_ONES   = OFS_ZEROS + CNT_W;
  localparam int OFS_LAG    = OFS_ONES + CNT_W;
  localparam int OFS_SUM    = OFS_LAG + LAG_W;
  localparam int OUT_USED_W = OFS_SUM + SUM_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_IVL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_IVL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_LIMIT = 2'd2;

  localparam logic [IVL_W-1:0] BIAS_IVL_RST  = 16'd100;
  localparam logic [IVL_W-1:0] CORR_IVL_RST  = 16'd200;
  localparam logic [CNT_W-1:0] BIT_LIMIT_RST = 20'd10000;

  typedef enum logic [KIND_W-1:0] {
    KIND_BIAS = 2'd0,
    KIND_CORR = 2'd1,
    KIND_FIN  = 2'd2
  } kind_e;

  // front to back command, one per analysed or finishing bit
  typedef struct packed {
    logic             rand_bit;
    logic             analyse;
    logic             do_bias;
    logic             do_corr;
    logic             do_fin;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] zeros;
    logic [CNT_W-1:0] ones;
  } cmd_t;

  typedef struct packed {
    kind_e                    kind;
    logic [CNT_W-1:0]         total;
    logic [CNT_W-1:0]         zeros;
    logic [CNT_W-1:0]         ones;
    logic [LAG_W-1:0]         lag;
    logic signed [SUM_W-1:0]  corr_sum;
    logic                     last;
  } res_t;

  // clamp an accumulator into the signed output range
  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] a);
    logic signed [31:0] w;
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    w  = 32'(a);
    hi = (32'sd1 <<< (SUM_W - 1)) - 32'sd1;
    lo = -(32'sd1 <<< (SUM_W - 1));
    if (w > hi) begin
      w = hi;
    end else if (w < lo) begin
      w = lo;
    end
    return w[SUM_W-1:0];
  endfunction

endpackage

FILE: rtl/rng_bias_autocorrelation_monitor.sv
// top level of the random bit health monitor: front end, command queue, back end
// depends on rbam_pkg, rbam_front, rbam_queue, rbam_back
`timescale 1ns / 1ps

// random bit health monitor. one random bit per input request (tdata bit 0, 1 counts as +1,
// 0 as -1). zeros, ones and the total are counted; every bias_interval bits a bias report
// goes out, and every corr_interval bits a burst of LAG_COUNT circular autocorrelation sums
// (lags 1 up) over the last min(total, RING_DEPTH) bits of the ring. once the total reaches
// the bit limit register the next request yields one finished result and everything after
// it is dropped until reset. an interval of zero switches that report off.
// a bit that causes no report is retired without leaving S_IDLE; the front can run one
// request per cycle until the two-entry queue fills. a bias report adds the S_BIAS
// state in the back end. a correlation burst walks W + LAG_COUNT ring reads, one per
// cycle (W = min(total, RING_DEPTH)), then emits one lag result at a time from S_EMIT.
// a write to either interval register restarts a bit-serial rebuild of the bias and
// then the correlation remainder, during which no request is taken. the ring needs no
// clearing after reset: only entries already written are read.

module rng_bias_autocorrelation_monitor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [rbam_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rbam_pkg::CFG_W-1:0]          cfg_wdata_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rbam_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [0] rand_bit
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [19:0] total_count, [39:20] zero_count, [59:40] one_count, [64:60] lag,
  // [73:65] corr_sum, rest zero
  output logic [rbam_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [rbam_pkg::KIND_W-1:0]         m_axis_tuser,  // [1:0] kind
  output logic                                m_axis_tlast
);
  import rbam_pkg::*;

  logic push, q_full, q_valid, q_pop;
  cmd_t push_cmd, q_cmd;
  res_t res;

  // front: counters and report decisions, runs ahead of the ring walk
  rbam_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_bit_i    (s_axis_tdata[0]),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  // decouples the front from a back end busy with a burst
  rbam_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd)
  );

  // back: ring writes in arrival order, reports, correlation walk
  rbam_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // result packing, lowest field first
  assign m_axis_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, res.corr_sum, res.lag,
                         res.ones, res.zeros, res.total};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

FILE: rtl/rbam_front.sv
// front end: config registers, bit counters, interval remainders, item classification
// depends on rbam_pkg
`timescale 1ns / 1ps

module rbam_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rbam_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbam_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_bit_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output rbam_pkg::cmd_t                  push_cmd_o
);
  import rbam_pkg::*;

  logic [IVL_W-1:0]    bias_ivl_q, corr_ivl_q;
  logic [CNT_W-1:0]    bit_limit_q;
  logic [CNT_W-1:0]    total_q, total_d, zeros_q, zeros_d, ones_q, ones_d;
  logic [IVL_W-1:0]    rem_b_q, rem_b_d, rem_c_q, rem_c_d;
  logic                halted_q, halted_d;
  logic                rc_busy_q, rc_busy_d, rc_sel_q, rc_sel_d;
  logic [RC_BIT_W-1:0] rc_bit_q, rc_bit_d;
  logic [IVL_W-1:0]    rc_rem_q, rc_rem_d;

  logic                accept;
  logic                ivl_write;
  logic [IVL_W:0]      rem_sh, rem_sub, div_ext;
  logic [IVL_W-1:0]    rem_nx;
  logic [IVL_W:0]      rem_b_inc, rem_c_inc;
  logic                hit_b, hit_c;

  assign in_ready_o = !rc_busy_q && (halted_q || !q_full_i);
  assign accept     = in_valid_i && in_ready_o;
  assign ivl_write  = cfg_we_i && ((cfg_idx_i == REG_BIAS_IVL) || (cfg_idx_i == REG_CORR_IVL));

  // one restoring remainder step per cycle
  assign div_ext = {1'b0, (rc_sel_q ? corr_ivl_q : bias_ivl_q)};
  assign rem_sh  = {rc_rem_q, total_q[rc_bit_q]};
  assign rem_sub = rem_sh - div_ext;
  assign rem_nx  = (rem_sh >= div_ext) ? rem_sub[IVL_W-1:0] : rem_sh[IVL_W-1:0];

  assign rem_b_inc = {1'b0, rem_b_q} + (IVL_W+1)'(1);
  assign rem_c_inc = {1'b0, rem_c_q} + (IVL_W+1)'(1);
  assign hit_b     = (bias_ivl_q != '0) && (rem_b_inc == {1'b0, bias_ivl_q});
  assign hit_c     = (corr_ivl_q != '0) && (rem_c_inc == {1'b0, corr_ivl_q});

  always_comb begin
    total_d    = total_q;
    zeros_d    = zeros_q;
    ones_d     = ones_q;
    rem_b_d    = rem_b_q;
    rem_c_d    = rem_c_q;
    halted_d   = halted_q;
    rc_busy_d  = rc_busy_q;
    rc_sel_d   = rc_sel_q;
    rc_bit_d   = rc_bit_q;
    rc_rem_d   = rc_rem_q;
    push_o     = 1'b0;
    push_cmd_o = '0;

    if (accept && !halted_q) begin
      push_o              = 1'b1;
      push_cmd_o.rand_bit = in_bit_i;
      if (total_q >= bit_limit_q) begin
        // limit reached: this bit is dropped, only the finish result follows
        push_cmd_o.do_fin = 1'b1;
        push_cmd_o.total  = total_q;
        push_cmd_o.zeros  = zeros_q;
        push_cmd_o.ones   = ones_q;
        halted_d          = 1'b1;
      end else begin
        total_d = total_q + CNT_W'(1);
        if (in_bit_i) begin
          ones_d = ones_q + CNT_W'(1);
        end else begin
          zeros_d = zeros_q + CNT_W'(1);
        end
        rem_b_d = hit_b ? '0 : rem_b_inc[IVL_W-1:0];
        rem_c_d = hit_c ? '0 : rem_c_inc[IVL_W-1:0];
        push_cmd_o.analyse = 1'b1;
        push_cmd_o.do_bias = hit_b;
        push_cmd_o.do_corr = hit_c;
        push_cmd_o.total   = total_d;
        push_cmd_o.zeros   = zeros_d;
        push_cmd_o.ones    = ones_d;
      end
    end

    if (ivl_write) begin
      // new interval: rebuild both remainders from the bit count
      rc_busy_d = 1'b1;
      rc_sel_d  = 1'b0;
      rc_bit_d  = RC_BIT_W'(CNT_W - 1);
      rc_rem_d  = '0;
    end else if (rc_busy_q) begin
      if (rc_bit_q == '0) begin
        if (!rc_sel_q) begin
          rem_b_d  = rem_nx;
          rc_sel_d = 1'b1;
          rc_bit_d = RC_BIT_W'(CNT_W - 1);
          rc_rem_d = '0;
        end else begin
          rem_c_d   = rem_nx;
          rc_busy_d = 1'b0;
        end
      end else begin
        rc_bit_d = rc_bit_q - RC_BIT_W'(1);
        rc_rem_d = rem_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_ivl_q  <= BIAS_IVL_RST;
      corr_ivl_q  <= CORR_IVL_RST;
      bit_limit_q <= BIT_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BIAS_IVL:  bias_ivl_q  <= cfg_wdata_i[IVL_W-1:0];
        REG_CORR_IVL:  corr_ivl_q  <= cfg_wdata_i[IVL_W-1:0];
        REG_BIT_LIMIT: bit_limit_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      zeros_q   <= '0;
      ones_q    <= '0;
      rem_b_q   <= '0;
      rem_c_q   <= '0;
      halted_q  <= 1'b0;
      rc_busy_q <= 1'b0;
      rc_sel_q  <= 1'b0;
      rc_bit_q  <= '0;
      rc_rem_q  <= '0;
    end else begin
      total_q   <= total_d;
      zeros_q   <= zeros_d;
      ones_q    <= ones_d;
      rem_b_q   <= rem_b_d;
      rem_c_q   <= rem_c_d;
      halted_q  <= halted_d;
      rc_busy_q <= rc_busy_d;
      rc_sel_q  <= rc_sel_d;
      rc_bit_q  <= rc_bit_d;
      rc_rem_q  <= rc_rem_d;
    end
  end

endmodule

FILE: rtl/rbam_queue.sv
// short command queue between front and back end
// depends on rbam_pkg
`timescale 1ns / 1ps

module rbam_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rbam_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rbam_pkg::cmd_t cmd_o
);
  import rbam_pkg::*;

  cmd_t                slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
    return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/rbam_back.sv
// back end: bit ring, autocorrelation walk with per-lag accumulators, result register
// depends on rbam_pkg
`timescale 1ns / 1ps

module rbam_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  rbam_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rbam_pkg::res_t out_res_o
);
  import rbam_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_BIAS = 5'b00010,
    S_WALK = 5'b00100,
    S_EMIT = 5'b01000,
    S_FIN  = 5'b10000
  } bstate_e;

  localparam logic signed [ACC_W-1:0] ACC_ONE  = ACC_W'(1);
  localparam logic signed [ACC_W-1:0] ACC_MONE = '1;

  bstate_e state_q, state_d;
  cmd_t    cmd_q, cmd_d;

  logic                     ring_mem [RING_DEPTH];
  logic [RING_AW-1:0]       wpos_q, wpos_d;
  logic                     ring_we, ring_re;
  logic                     rd_data_q;
  logic                     rd_vld_q;

  logic [RING_AW-1:0]       addr_q, addr_d;
  logic [LEN_W-1:0]         iss_cnt_q, iss_cnt_d, proc_cnt_q, proc_cnt_d;
  logic [LAG_COUNT-1:0]     sr_q, sr_d;
  logic [LAG_COUNT:0]       win_bits;
  logic signed [ACC_W-1:0]  acc_q [LAG_COUNT];
  logic signed [ACC_W-1:0]  acc_d [LAG_COUNT];
  logic [LAG_IW-1:0]        emit_idx_q, emit_idx_d;

  logic [WIN_W-1:0]         win, win_m1;
  logic [LEN_W-1:0]         len;
  logic                     walk_init;
  logic                     accum;

  logic                     out_vld_q, out_vld_d;
  res_t                     out_q, res;
  logic                     emit, out_free;

  assign win    = (cmd_q.total >= CNT_W'(RING_DEPTH)) ? WIN_W'(RING_DEPTH)
                                                      : cmd_q.total[WIN_W-1:0];
  assign win_m1 = win - WIN_W'(1);
  assign len    = LEN_W'(win) + LEN_W'(LAG_COUNT);

  assign out_free    = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

  // oldest of the last LAG_COUNT+1 ring values sits at the top
  assign win_bits = {sr_q, rd_data_q};
  assign accum    = rd_vld_q && (proc_cnt_q >= LEN_W'(LAG_COUNT));

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    wpos_d     = wpos_q;
    q_pop_o    = 1'b0;
    ring_we    = 1'b0;
    ring_re    = 1'b0;
    walk_init  = 1'b0;
    emit       = 1'b0;
    res        = '0;
    emit_idx_d = emit_idx_q;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          if (q_cmd_i.analyse) begin
            ring_we = 1'b1;
            wpos_d  = (wpos_q == RING_AW'(RING_DEPTH - 1)) ? '0 : wpos_q + RING_AW'(1);
          end
          if (q_cmd_i.do_fin) begin
            state_d = S_FIN;
          end else if (q_cmd_i.do_bias) begin
            state_d = S_BIAS;
          end else if (q_cmd_i.do_corr) begin
            state_d   = S_WALK;
            walk_init = 1'b1;
          end
        end
      end
      S_BIAS: begin
        if (out_free) begin
          emit      = 1'b1;
          res.kind  = KIND_BIAS;
          res.last  = !cmd_q.do_corr;
          if (cmd_q.do_corr) begin
            state_d   = S_WALK;
            walk_init = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_WALK: begin
        ring_re = (iss_cnt_q < len);
        if (rd_vld_q && (proc_cnt_q == len - LEN_W'(1))) begin
          state_d    = S_EMIT;
          emit_idx_d = '0;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit         = 1'b1;
          res.kind     = KIND_CORR;
          res.lag      = LAG_W'(emit_idx_q) + LAG_W'(1);
          res.corr_sum = sat_sum(acc_q[emit_idx_q]);
          res.last     = (emit_idx_q == LAG_IW'(LAG_COUNT - 1));
          if (res.last) begin
            state_d = S_IDLE;
          end else begin
            emit_idx_d = emit_idx_q + LAG_IW'(1);
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          emit     = 1'b1;
          res.kind = KIND_FIN;
          res.last = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    res.total = cmd_q.total;
    res.zeros = cmd_q.zeros;
    res.ones  = cmd_q.ones;
  end

  // walk read side: addresses wrap at the window
  always_comb begin
    iss_cnt_d  = iss_cnt_q;
    addr_d     = addr_q;
    proc_cnt_d = proc_cnt_q;
    sr_d       = sr_q;
    if (walk_init) begin
      iss_cnt_d  = '0;
      addr_d     = '0;
      proc_cnt_d = '0;
    end else begin
      if (ring_re) begin
        iss_cnt_d = iss_cnt_q + LEN_W'(1);
        addr_d    = (WIN_W'(addr_q) == win_m1) ? '0 : addr_q + RING_AW'(1);
      end
      if (rd_vld_q) begin
        proc_cnt_d = proc_cnt_q + LEN_W'(1);
        sr_d       = win_bits[LAG_COUNT-1:0];
      end
    end
  end

  // one lane per lag: +1 on a match with the value l+1 places later, -1 otherwise
  always_comb begin
    for (int l = 0; l < LAG_COUNT; l++) begin
      if (walk_init) begin
        acc_d[l] = '0;
      end else if (accum) begin
        acc_d[l] = acc_q[l] +
                   ((win_bits[LAG_COUNT] == win_bits[LAG_COUNT-1-l]) ? ACC_ONE : ACC_MONE);
      end else begin
        acc_d[l] = acc_q[l];
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wpos_q] <= q_cmd_i.rand_bit;
    end
    if (ring_re) begin
      rd_data_q <= ring_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    sr_q  <= sr_d;
    for (int l = 0; l < LAG_COUNT; l++) begin
      acc_q[l] <= acc_d[l];
    end
    if (emit) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      wpos_q     <= '0;
      rd_vld_q   <= 1'b0;
      addr_q     <= '0;
      iss_cnt_q  <= '0;
      proc_cnt_q <= '0;
      emit_idx_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      wpos_q     <= wpos_d;
      rd_vld_q   <= ring_re;
      addr_q     <= addr_d;
      iss_cnt_q  <= iss_cnt_d;
      proc_cnt_q <= proc_cnt_d;
      emit_idx_q <= emit_idx_d;
      out_vld_q  <= out_vld_d;
    end
  end

endmodule

FILE: rtl/rbam_checker.sv
// port-level checks on the result stream of the random bit health monitor
// depends on rbam_pkg and the assertion macro header; bound to the top level below
`timescale 1ns / 1ps
`include "rng_bias_autocorrelation_monitor_assert.svh"

module rbam_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rbam_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [rbam_pkg::KIND_W-1:0]     m_axis_tuser,
  input logic                            m_axis_tlast
);
  import rbam_pkg::*;

  logic             stalled;
  logic [CNT_W:0]   count_sum;
  logic             not_corr;

  assign stalled   = m_axis_tvalid && !m_axis_tready;
  assign count_sum = {1'b0, m_axis_tdata[OFS_ZEROS +: CNT_W]} +
                     {1'b0, m_axis_tdata[OFS_ONES +: CNT_W]};
  assign not_corr  = (m_axis_tuser == KIND_BIAS) || (m_axis_tuser == KIND_FIN);

  // a held result stays put
  `RBAM_ASSERT_NEXT(a_hold_valid, stalled, m_axis_tvalid)
  `RBAM_ASSERT_NEXT(a_hold_data, stalled, $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // finish closes its own burst
  `RBAM_ASSERT_NOW(a_fin_last, m_axis_tvalid && (m_axis_tuser == KIND_FIN), m_axis_tlast)
  // only correlation results carry a lag and a sum
  `RBAM_ASSERT_NOW(a_no_lag, m_axis_tvalid && not_corr, m_axis_tdata[OUT_USED_W-1:OFS_LAG] == '0)
  // every analysed bit is either a zero or a one
  `RBAM_ASSERT_NOW(a_counts, m_axis_tvalid, count_sum == {1'b0, m_axis_tdata[OFS_TOTAL +: CNT_W]})

endmodule

bind rng_bias_autocorrelation_monitor rbam_checker u_rbam_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
